// File: rtl/dominant_direction_coder_macros.svh
// Assertion macros used by the checker file of the coder.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef DOMINANT_DIRECTION_CODER_MACROS_SVH
`define DOMINANT_DIRECTION_CODER_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define DDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define DDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `DDC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/ddc_pkg.sv
package ddc_pkg;

  // Default configuration of the coder.
  localparam int MAX_DIRECTIONS_DEF = 8;
  localparam int RESPONSE_BITS_DEF  = 16;

  // Direction count register.
  localparam int              COUNT_BITS  = 4;
  localparam logic [3:0]      COUNT_RESET = 4'd6;

  // Result fields.
  localparam int DIR_BITS   = 3;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - DIR_BITS - 1;

  typedef struct packed {
    logic                side_bit;
    logic [DIR_BITS-1:0] dominant_direction;
  } result_t;

endpackage

// File: rtl/ddc_cfg.sv
module ddc_cfg #(
  parameter int MAX_DIRECTIONS = ddc_pkg::MAX_DIRECTIONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic [ddc_pkg::COUNT_BITS-1:0]        wr_data,
  output logic [$clog2(MAX_DIRECTIONS+1)-1:0]   count
);
  import ddc_pkg::*;

  localparam int CW = $clog2(MAX_DIRECTIONS + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // Zero counts as one direction; anything above the lane count saturates.
  function automatic logic [CW-1:0] clamp_count(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] c;
    c = v;
    if (c == '0) begin
      c = COUNT_BITS'(1);
    end else if (c > COUNT_BITS'(MAX_DIRECTIONS)) begin
      c = COUNT_BITS'(MAX_DIRECTIONS);
    end
    return CW'(c);
  endfunction

  always_comb begin
    count_nxt = count_r;
    if (wr_en) begin
      count_nxt = clamp_count(wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= clamp_count(COUNT_RESET);
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

// File: rtl/ddc_core.sv
module ddc_core #(
  parameter int MAX_DIRECTIONS = ddc_pkg::MAX_DIRECTIONS_DEF,
  parameter int RESPONSE_BITS  = ddc_pkg::RESPONSE_BITS_DEF
) (
  input  logic [MAX_DIRECTIONS-1:0][RESPONSE_BITS-1:0] lane,
  input  logic [$clog2(MAX_DIRECTIONS+1)-1:0]          count,
  output ddc_pkg::result_t                             res
);
  import ddc_pkg::*;

  localparam int CW     = $clog2(MAX_DIRECTIONS + 1);
  localparam int IW     = $clog2(MAX_DIRECTIONS);
  localparam int LEAVES = 1 << IW;

  // Heap-ordered compare tree: node k combines nodes 2k (lower lanes) and 2k+1.
  logic [RESPONSE_BITS-1:0] node_val [1:2*LEAVES-1];
  logic [IW-1:0]            node_idx [1:2*LEAVES-1];
  logic                     node_ok  [1:2*LEAVES-1];

  logic [IW-1:0]            best;
  logic [CW-1:0]            best_c;
  logic [CW-1:0]            next_c;
  logic [CW-1:0]            prev_c;
  logic [RESPONSE_BITS-1:0] next_val;
  logic [RESPONSE_BITS-1:0] prev_val;

  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < MAX_DIRECTIONS) begin : g_used
      assign node_val[LEAVES+g] = lane[g];
      assign node_ok[LEAVES+g]  = (CW'(g) < count);
    end else begin : g_pad
      assign node_val[LEAVES+g] = '0;
      assign node_ok[LEAVES+g]  = 1'b0;
    end
    assign node_idx[LEAVES+g] = IW'(g);
  end

  // The higher lane wins only when strictly greater, so ties keep the lower index.
  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    logic take_hi;
    assign take_hi = node_ok[2*k+1] &&
                     (!node_ok[2*k] || (node_val[2*k+1] > node_val[2*k]));
    assign node_val[k] = take_hi ? node_val[2*k+1] : node_val[2*k];
    assign node_idx[k] = take_hi ? node_idx[2*k+1] : node_idx[2*k];
    assign node_ok[k]  = node_ok[2*k] || node_ok[2*k+1];
  end

  assign best   = node_idx[1];
  assign best_c = CW'(best);

  always_comb begin
    next_c   = ((best_c + CW'(1)) == count) ? '0 : (best_c + CW'(1));
    prev_c   = (best_c == '0) ? (count - CW'(1)) : (best_c - CW'(1));
    next_val = '0;
    prev_val = '0;
    for (int i = 0; i < MAX_DIRECTIONS; i++) begin
      if (CW'(i) == next_c) begin
        next_val = next_val | lane[i];
      end
      if (CW'(i) == prev_c) begin
        prev_val = prev_val | lane[i];
      end
    end
    res.dominant_direction = DIR_BITS'(best);
    res.side_bit           = (next_val >= prev_val);
  end

endmodule

// File: rtl/dominant_direction_coder.sv
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    in_tdata: response_0 .. response_N-1, lane 0 lowest
// out_     out  out_tvalid/out_tready  out_tdata: dominant_direction, side_bit
// cfg_     in   cfg_valid/cfg_ready    cfg_data: direction_count
//
// One pixel is taken per cycle while the output is not stalled; its result passes through
// the input register and then the result register, around one compare tree, before it
// is offered. Reset (synchronous, rst_n low) empties both stages and sets the direction
// count to six. A stalled output holds its result while the input register can still
// take one more pixel; cfg_ready is always high and a write takes effect next cycle.
module dominant_direction_coder #(
  parameter int MAX_DIRECTIONS = ddc_pkg::MAX_DIRECTIONS_DEF,
  parameter int RESPONSE_BITS  = ddc_pkg::RESPONSE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input pixel transfers.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0 up: response_0, response_1, ... each RESPONSE_BITS wide,
  // zero padded to whole bytes.
  input  logic [((MAX_DIRECTIONS*RESPONSE_BITS+7)/8)*8-1:0] in_tdata,
  // Result transfers.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // Fields from bit 0 up: dominant_direction [2:0], side_bit [3], zeros [7:4].
  output logic [ddc_pkg::OUT_DATA_W-1:0]        out_tdata,
  // Direction count register writes.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ddc_pkg::COUNT_BITS-1:0]        cfg_data
);
  import ddc_pkg::*;

  localparam int CW = $clog2(MAX_DIRECTIONS + 1);

  logic [CW-1:0] count;

  // Stage 1 holds the raw lanes of one pixel.
  logic                                        s1_valid_r;
  logic                                        s1_valid_nxt;
  logic [MAX_DIRECTIONS-1:0][RESPONSE_BITS-1:0] lane_r;
  logic [MAX_DIRECTIONS-1:0][RESPONSE_BITS-1:0] lane_nxt;

  // Stage 2 holds the finished result until the output transfer.
  logic     s2_valid_r;
  logic     s2_valid_nxt;
  result_t  res_r;
  result_t  res_nxt;
  result_t  core_res;

  logic s2_ready;
  logic s1_ready;

  assign cfg_ready = 1'b1;

  ddc_cfg #(
    .MAX_DIRECTIONS (MAX_DIRECTIONS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_data (cfg_data),
    .count   (count)
  );

  ddc_core #(
    .MAX_DIRECTIONS (MAX_DIRECTIONS),
    .RESPONSE_BITS  (RESPONSE_BITS)
  ) u_core (
    .lane  (lane_r),
    .count (count),
    .res   (core_res)
  );

  // Each stage can load when it is empty or when its contents move on this cycle.
  assign s2_ready  = !s2_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    lane_nxt     = lane_r;
    if (s1_ready) begin
      s1_valid_nxt = in_tvalid;
      lane_nxt     = in_tdata[MAX_DIRECTIONS*RESPONSE_BITS-1:0];
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    res_nxt      = res_r;
    if (s2_ready) begin
      s2_valid_nxt = s1_valid_r;
      res_nxt      = core_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), res_r.side_bit, res_r.dominant_direction};

endmodule

// File: rtl/ddc_checker.sv
`include "dominant_direction_coder_macros.svh"

module ddc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ddc_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import ddc_pkg::*;

  // A result that waits for the consumer must not change.
  `DDC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // Once an accepted pixel has had time to pass the input and result registers, out_tvalid must be high.
  `DDC_ASSERT(a_latency, (in_tvalid && in_tready) |=> ##1 out_tvalid, "accepted pixel produced no result")

  // With the result register empty the input side must be open.
  `DDC_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input blocked with empty output")

  // A draining output always frees room for a new pixel.
  `DDC_ASSERT(a_ready_on_drain, (out_tvalid && out_tready) |-> in_tready, "input blocked while output drains")

endmodule

bind dominant_direction_coder ddc_checker u_ddc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/dominant_direction_checker.sv
`default_nettype none

// Watches the pixel, result and count-write channels of the coder. It keeps its own
// copy of the direction count and predicts one code per accepted pixel. Each result
// transfer is compared field by field with the oldest prediction.
module dominant_direction_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_tready,
  input  wire logic [127:0]        in_tdata,
  input  wire logic                out_tvalid,
  input  wire logic                out_tready,
  input  wire logic [7:0]          out_tdata,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [3:0]          cfg_data,
  output int                       mismatch_count,
  output int                       pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES  = ddc_pkg::MAX_DIRECTIONS_DEF;
  localparam int LANE_W = ddc_pkg::RESPONSE_BITS_DEF;
  localparam int IN_W   = ((LANES * LANE_W + 7) / 8) * 8;

  logic [ddc_pkg::COUNT_BITS-1:0] count_setting;
  ddc_pkg::result_t               expected_codes[$];
  int                             fail_tally = 0;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    count_setting   = ddc_pkg::COUNT_RESET;
  end

  // Strongest used lane (lowest index on ties) and which circular neighbor wins.
  function automatic ddc_pkg::result_t code_pixel(input logic [IN_W-1:0] pixel,
                                                  input logic [ddc_pkg::COUNT_BITS-1:0] setting);
    logic [LANE_W-1:0] lane [LANES];
    int                n;
    int                best;
    int                nxt;
    int                prv;
    ddc_pkg::result_t  code;
    n = int'(setting);
    if (n < 1) n = 1;
    if (n > LANES) n = LANES;
    for (int i = 0; i < LANES; i++) lane[i] = pixel[i*LANE_W +: LANE_W];
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (lane[i] > lane[best]) best = i;
    end
    nxt = (best + 1 == n) ? 0 : best + 1;
    prv = (best == 0) ? n - 1 : best - 1;
    code.dominant_direction = best[ddc_pkg::DIR_BITS-1:0];
    code.side_bit           = (lane[nxt] >= lane[prv]);
    return code;
  endfunction

  always @(posedge clk) begin : watch
    ddc_pkg::result_t want;
    ddc_pkg::result_t got;
    if (!rst_n) begin
      count_setting = ddc_pkg::COUNT_RESET;
      expected_codes.delete();
    end else begin
      // A pixel taken on the same edge as a count write is coded with the new count.
      if (cfg_valid && cfg_ready) count_setting = cfg_data;
      if (in_tvalid && in_tready) begin
        expected_codes = {expected_codes, code_pixel(in_tdata, count_setting)};
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[ddc_pkg::DIR_BITS:0];
        if (expected_codes.size() == 0) begin
          $display("%0t: result %h arrived with no pixel outstanding", $time, out_tdata);
          fail_tally++;
        end else begin
          want = expected_codes.pop_front();
          if (got.dominant_direction !== want.dominant_direction) begin
            $display("%0t: dominant_direction expected %0d, got %0d", $time,
                     want.dominant_direction, got.dominant_direction);
            fail_tally++;
          end
          if (got.side_bit !== want.side_bit) begin
            $display("%0t: side_bit expected %0b, got %0b", $time, want.side_bit, got.side_bit);
            fail_tally++;
          end
          if (out_tdata[ddc_pkg::OUT_DATA_W-1:ddc_pkg::DIR_BITS+1] !== '0) begin
            $display("%0t: padding expected 0, got %h", $time,
                     out_tdata[ddc_pkg::OUT_DATA_W-1:ddc_pkg::DIR_BITS+1]);
            fail_tally++;
          end
        end
      end
    end
    pending_results <= expected_codes.size();
    mismatch_count  <= fail_tally;
  end

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

// Stimulus and verdict for the dominant direction coder. The checker beside the block
// does all prediction and comparison; this module only produces traffic, moves the
// direction count between phases, and reports the outcome.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES  = ddc_pkg::MAX_DIRECTIONS_DEF;
  localparam int LANE_W = ddc_pkg::RESPONSE_BITS_DEF;
  localparam int IN_W   = ((LANES * LANE_W + 7) / 8) * 8;

  // Random part: one phase per direction count, each with this many pixels.
  localparam int PHASES           = 12;
  localparam int PIXELS_PER_PHASE = 88;
  // Percentages of cycles in which a side idles.
  localparam int IDLE_PCT         = 53;
  localparam int IDLE_BOTH_PCT    = 25;
  // Long receiver hold-off that makes the block fill up and stall its input.
  localparam int HOLD_CYCLES      = 300;
  // A result is offered once its pixel has passed the input and result registers; wait longer than that.
  localparam int SETTLE_CYCLES    = 6;
  localparam int CYCLE_LIMIT      = 200000;

  typedef enum logic [1:0] {
    PIX_UNIFORM,   // every lane independent over the full range
    PIX_POOL,      // lanes drawn from a few values, so ties are common
    PIX_FLAT,      // all lanes equal
    PIX_EXTREME    // lanes near zero or near full scale
  } pixel_kind_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  // Fields from bit 0 up: response_0 .. response_7, 16 bits each.
  logic [IN_W-1:0]                in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  // Fields from bit 0 up: dominant_direction [2:0], side_bit [3], zeros [7:4].
  logic [ddc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ddc_pkg::COUNT_BITS-1:0] cfg_data;

  int                             mismatch_count;
  int                             pending_results;

  // Idling knobs, written by the stimulus process; hold_taken is set by the receiver.
  int                             sender_idle_pct    = 0;
  int                             receiver_stall_pct = 0;
  logic                           want_hold          = 1'b0;
  logic                           hold_taken         = 1'b0;

  logic [LANE_W-1:0]              lane_buf [LANES];
  int                             cycle_count        = 0;

  dominant_direction_coder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  dominant_direction_checker code_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A runaway run is cut off here; a result that never shows up ends this way too.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side. Outside the single long hold-off, tready is drawn every cycle from
  // the current stall percentage. The hold-off is counted here, in its own process,
  // so that the sender keeps offering pixels while the block backs up.
  initial begin : receiver
    int hold_left;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (want_hold && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Offers one pixel and returns at the edge where its transfer happens. Idle cycles
  // carry random noise on tdata so that the block must ignore data without tvalid.
  task automatic push_pixel(input logic [IN_W-1:0] pixel);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom, $urandom, $urandom};
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pixel;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_lanes();
    logic [IN_W-1:0] pixel;
    pixel = '0;
    for (int i = 0; i < LANES; i++) pixel[i*LANE_W +: LANE_W] = lane_buf[i];
    push_pixel(pixel);
  endtask

  // Fills lane_buf with a random pixel. Most are shaped so that ties between lanes
  // and equal neighbors come up often, since those decide index and side bit.
  task automatic random_lanes();
    pixel_kind_t          kind;
    int                   pick;
    logic [LANE_W-1:0]    pool [3];
    pick = $urandom_range(9);
    if (pick < 4)      kind = PIX_UNIFORM;
    else if (pick < 7) kind = PIX_POOL;
    else if (pick < 8) kind = PIX_FLAT;
    else               kind = PIX_EXTREME;
    for (int i = 0; i < 3; i++) pool[i] = LANE_W'($urandom_range(16'hFFFF));
    for (int i = 0; i < LANES; i++) begin
      case (kind)
        PIX_UNIFORM: begin
          lane_buf[i] = LANE_W'($urandom_range(16'hFFFF));
        end
        PIX_POOL: begin
          lane_buf[i] = pool[$urandom_range(2)];
        end
        PIX_FLAT: begin
          lane_buf[i] = pool[0];
        end
        default: begin
          lane_buf[i] = $urandom_range(1) ? LANE_W'(16'hFFFF - $urandom_range(1))
                                          : LANE_W'($urandom_range(1));
        end
      endcase
    end
  endtask

  // Count writes happen only with the block empty: the input is already idle, so we
  // wait for every outstanding result and then a few more cycles before the write.
  task automatic write_count(input logic [ddc_pkg::COUNT_BITS-1:0] setting);
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= setting;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [ddc_pkg::COUNT_BITS-1:0] count_plan [PHASES];

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels at the reset count of six, with both sides always ready.
    // All lanes zero and all lanes at full scale: index 0, neighbors equal.
    for (int i = 0; i < LANES; i++) lane_buf[i] = '0;
    send_lanes();
    for (int i = 0; i < LANES; i++) lane_buf[i] = 16'hFFFF;
    send_lanes();
    // A single peak in each lane. The peak in lane 0 wraps its lower neighbor to the
    // last used lane, the one in lane 5 wraps its upper neighbor to lane 0, and the
    // peaks in lanes 6 and 7 lie above the count and must be ignored.
    for (int k = 0; k < LANES; k++) begin
      for (int i = 0; i < LANES; i++) lane_buf[i] = LANE_W'($urandom_range(16'h7FFF));
      lane_buf[k] = 16'hFFFF;
      send_lanes();
    end
    // Two equal peaks: the lower index wins.
    for (int i = 0; i < LANES; i++) lane_buf[i] = 16'h0100;
    lane_buf[2] = 16'hF000;
    lane_buf[4] = 16'hF000;
    send_lanes();
    // Peak in the last used lane with equal neighbors on both sides of the wrap.
    for (int i = 0; i < LANES; i++) lane_buf[i] = 16'h0010;
    lane_buf[5] = 16'h8000;
    lane_buf[0] = 16'h4000;
    lane_buf[4] = 16'h4000;
    send_lanes();
    // Peak in lane 0 whose wrapped lower neighbor is the stronger one.
    for (int i = 0; i < LANES; i++) lane_buf[i] = '0;
    lane_buf[0] = 16'hC000;
    lane_buf[1] = 16'h0001;
    lane_buf[5] = 16'h0002;
    send_lanes();
    // Alternating bit patterns across the lanes.
    for (int i = 0; i < LANES; i++) lane_buf[i] = i[0] ? 16'hAAAA : 16'h5555;
    send_lanes();
    in_tvalid <= 1'b0;

    // Random phases. The counts cover the full range, a single direction, zero (taken
    // as one), values above eight (saturating) and the reset value.
    count_plan = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd9, 4'd3, 4'd4, 4'd5, 4'd7, 4'd6, 4'd12};
    for (int p = 0; p < PHASES; p++) begin
      write_count(count_plan[p]);
      // Rotate through the idling patterns so each pattern is used with three of the counts.
      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = IDLE_PCT;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = IDLE_PCT;
        end
        default: begin
          sender_idle_pct    = IDLE_BOTH_PCT;
          receiver_stall_pct = IDLE_BOTH_PCT;
        end
      endcase
      // One no-idle phase also gets the long receiver hold-off.
      if (p == 4) want_hold = 1'b1;
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        random_lanes();
        send_lanes();
      end
      in_tvalid <= 1'b0;
    end

    // Drain: every result must arrive, then give the block time to show anything extra.
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
